@@ rtl/dqds_pkg.sv @@
// Package for the deque with dedup and pair swap.
// Holds the transaction structs, operation and status codes and sizing constants.
package dqds_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_CLEAR      = 3'd4;
   localparam logic [2:0] OP_SWAP       = 3'd5;
   localparam logic [2:0] OP_DEDUP      = 3'd6;
   localparam logic [2:0] OP_UNUSED     = 3'd7;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_POP_EMPTY = 2'd1;
   localparam logic [1:0] ST_PUSH_FULL = 2'd2;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] data_in;
   } req_type;

   typedef struct packed {
      logic [31:0] popped_value;
      logic [31:0] front_value;
      logic [4:0]  count;
      logic        is_empty;
      logic [1:0]  status;
   } rsp_type;

endpackage

@@ rtl/dqds_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module dqds_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/deque_with_dedup_and_pair_swap.sv @@
// Top level of the deque with dedup and pair swap.
// Depends on dqds_pkg and dqds_ram.
//
//   channel  direction  payload                     handshake
//   req_     in         dqds_pkg::req_type          req_valid / req_stall
//   rsp_     out        dqds_pkg::rsp_type          rsp_valid / rsp_stall
//
// One transaction is worked on at a time. A push, clear or unused code passes
// through S_FRONT and S_RESP before its result is loaded into the output
// register; a pop that finds entries passes through S_POPRD first, since the
// popped word comes from the entry store, whose read is registered, and the new
// front word must then be read again. The next request is taken in the idle state.
// Swap walks the occupied span a pair at a time through S_SWRDA, S_SWRDB,
// S_SWWR and S_SWWR2. Dedup compares each entry against the kept entries until
// it finds a match, one memory read a cycle. Every operation ends by reading
// the front word, which is what the result reports.
// Reset is synchronous and clears the front index, the count, the output
// register's valid flag and the control state; the entry store itself is
// not cleared. A stalled result waits in the output register while the next
// request is taken and worked on; that request's result then waits in the
// last state, and the input is stalled, until the output register frees.
module deque_with_dedup_and_pair_swap
   import dqds_pkg::*;
#(
   parameter int DEPTH = dqds_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = dqds_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dqds_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dqds_pkg::rsp_type rsp_data
);
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   // One-hot sequencer states.
   typedef enum logic [10:0] {
      S_IDLE    = 11'b00000000001,
      S_POPRD   = 11'b00000000010,  // popped word read in flight
      S_SWRDA   = 11'b00000000100,  // swap: read first of pair
      S_SWRDB   = 11'b00000001000,  // swap: read second of pair
      S_SWWR    = 11'b00000010000,  // swap: write both back
      S_DDRDV   = 11'b00000100000,  // dedup: read candidate
      S_DDRDK   = 11'b00001000000,  // dedup: read kept entry
      S_DDCMP   = 11'b00010000000,  // dedup: compare
      S_FRONT   = 11'b00100000000,  // front word read in flight
      S_RESP    = 11'b01000000000,  // result waiting for the output register
      S_SWWR2   = 11'b10000000000   // swap: second write
   } state_type;

   state_type state_ff, state_in;
   logic [AW-1:0] front_ff, front_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] k_ff, k_in;        // walk position
   logic [CW-1:0] j_ff, j_in;        // kept-entry scan position
   logic [CW-1:0] n_ff, n_in;        // dedup kept count
   logic [DATA_WIDTH-1:0] va_ff, va_in;
   logic [31:0] popped_ff, popped_in;
   logic [1:0]  status_ff, status_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [DATA_WIDTH-1:0] wr_data, rd_data;

   dqds_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Ring position of an offset from the front; offsets stay below DEPTH.
   function automatic logic [AW-1:0] ring(input logic [AW-1:0] f, input logic [CW-1:0] o);
      logic [AW:0] s;
      s = {1'b0, f} + (AW+1)'(o);
      if (s >= (AW+1)'(DEPTH)) begin
         s = s - (AW+1)'(DEPTH);
      end
      return s[AW-1:0];
   endfunction

   logic [DATA_WIDTH-1:0] din;
   logic [AW-1:0] front_dec;
   assign din = DATA_WIDTH'(req_data.data_in);
   assign front_dec = (front_ff == '0) ? AW'(DEPTH - 1) : front_ff - AW'(1);

   function automatic logic [31:0] to32(input logic [DATA_WIDTH-1:0] v);
      logic [63:0] w;
      w = 64'(v);
      return w[31:0];
   endfunction

   always_comb begin
      state_in = state_ff;
      front_in = front_ff;
      count_in = count_ff;
      k_in = k_ff;
      j_in = j_ff;
      n_in = n_ff;
      va_in = va_ff;
      popped_in = popped_ff;
      status_in = status_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = din;
      rd_addr = front_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               popped_in = '0;
               status_in = ST_OK;
               state_in = S_FRONT;
               case (req_data.op)
                  OP_PUSH_FRONT: begin
                     if (count_ff == CW'(DEPTH)) begin
                        status_in = ST_PUSH_FULL;
                     end else begin
                        wr_en = 1'b1;
                        wr_addr = front_dec;
                        front_in = front_dec;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  OP_PUSH_BACK: begin
                     if (count_ff == CW'(DEPTH)) begin
                        status_in = ST_PUSH_FULL;
                     end else begin
                        wr_en = 1'b1;
                        wr_addr = ring(front_ff, count_ff);
                        count_in = count_ff + CW'(1);
                     end
                  end
                  OP_POP_FRONT: begin
                     if (count_ff == '0) begin
                        status_in = ST_POP_EMPTY;
                     end else begin
                        rd_addr = front_ff;
                        front_in = ring(front_ff, CW'(1));
                        count_in = count_ff - CW'(1);
                        state_in = S_POPRD;
                     end
                  end
                  OP_POP_BACK: begin
                     if (count_ff == '0) begin
                        status_in = ST_POP_EMPTY;
                     end else begin
                        rd_addr = ring(front_ff, count_ff - CW'(1));
                        count_in = count_ff - CW'(1);
                        state_in = S_POPRD;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     front_in = '0;
                  end
                  OP_SWAP: begin
                     k_in = '0;
                     state_in = S_SWRDA;
                  end
                  OP_DEDUP: begin
                     k_in = '0;
                     n_in = '0;
                     state_in = S_DDRDV;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_POPRD: begin
            popped_in = to32(rd_data);
            state_in = S_FRONT;
         end
         S_SWRDA: begin
            if ({1'b0, k_ff} + (CW+1)'(1) >= {1'b0, count_ff}) begin
               state_in = S_FRONT;
            end else begin
               rd_addr = ring(front_ff, k_ff);
               state_in = S_SWRDB;
            end
         end
         S_SWRDB: begin
            va_in = rd_data;
            rd_addr = ring(front_ff, k_ff + CW'(1));
            state_in = S_SWWR;
         end
         S_SWWR: begin
            wr_en = 1'b1;
            wr_addr = ring(front_ff, k_ff);
            wr_data = rd_data;
            state_in = S_SWWR2;
         end
         S_SWWR2: begin
            wr_en = 1'b1;
            wr_addr = ring(front_ff, k_ff + CW'(1));
            wr_data = va_ff;
            k_in = k_ff + CW'(2);
            state_in = S_SWRDA;
         end
         S_DDRDV: begin
            if (k_ff == count_ff) begin
               count_in = n_ff;
               state_in = S_FRONT;
            end else begin
               rd_addr = ring(front_ff, k_ff);
               j_in = '0;
               state_in = S_DDRDK;
            end
         end
         S_DDRDK: begin
            // First pass latches the candidate; later passes compare.
            if (j_ff == '0) begin
               va_in = rd_data;
            end
            if (j_ff == n_ff) begin
               // Not seen: keep it at the next kept slot.
               wr_en = 1'b1;
               wr_addr = ring(front_ff, n_ff);
               wr_data = (j_ff == '0) ? rd_data : va_ff;
               n_in = n_ff + CW'(1);
               k_in = k_ff + CW'(1);
               state_in = S_DDRDV;
            end else begin
               rd_addr = ring(front_ff, j_ff);
               state_in = S_DDCMP;
            end
         end
         S_DDCMP: begin
            if (rd_data == va_ff) begin
               k_in = k_ff + CW'(1);
               state_in = S_DDRDV;
            end else begin
               j_in = j_ff + CW'(1);
               if (j_ff + CW'(1) == n_ff) begin
                  wr_en = 1'b1;
                  wr_addr = ring(front_ff, n_ff);
                  wr_data = va_ff;
                  n_in = n_ff + CW'(1);
                  k_in = k_ff + CW'(1);
                  state_in = S_DDRDV;
               end else begin
                  rd_addr = ring(front_ff, j_ff + CW'(1));
               end
            end
         end
         S_FRONT: begin
            // Address front_ff was presented last cycle for most paths; read again here.
            rd_addr = front_ff;
            state_in = S_RESP;
         end
         S_RESP: begin
            // The result moves to the output register once that register is
            // empty or its transaction is taken at this edge.
            rd_addr = front_ff;
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in.popped_value = popped_ff;
               rsp_in.front_value = (count_ff == '0) ? 32'd0 : to32(rd_data);
               rsp_in.count = 5'(count_ff);
               rsp_in.is_empty = (count_ff == '0);
               rsp_in.status = status_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // rd_data in S_RESP is the front word read in S_FRONT; it is held since
   // the address does not change and no write occurs while waiting.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         front_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff <= k_in;
      j_ff <= j_in;
      n_ff <= n_in;
      va_ff <= va_in;
      popped_ff <= popped_in;
      status_ff <= status_in;
      rsp_ff <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for deque_with_dedup_and_pair_swap.
// Depends on dqds_pkg and the RTL of the block; it predicts each result from its own deque model.
module tb;
   import dqds_pkg::*;

   localparam int DEPTH = DEPTH_DEFAULT;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int QUIET_TAIL = 2000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;

   deque_with_dedup_and_pair_swap uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // Shadow copy of the deque: a plain ordered list, front at index 0.
   logic [31:0] shadow_list[$];
   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int mismatches = 0;
   int idle_cycles = 0;
   bit no_idling = 0;
   bit long_hold = 0;
   bit stimulus_done = 0;

   // Handshake state sampled at the rising edge, read by the driver afterwards.
   bit req_taken = 0;
   int accepted_reqs = 0;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Applies one operation to the shadow list and returns the result that the
   // block should report for it.
   function automatic rsp_type deque_apply(req_type r);
      rsp_type res;
      logic [31:0] kept[$];
      logic [31:0] t;
      bit seen;
      res = '0;
      res.status = ST_OK;
      case (r.op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (shadow_list.size() >= DEPTH) res.status = ST_PUSH_FULL;
            else if (r.op == OP_PUSH_FRONT) shadow_list.push_front(r.data_in);
            else shadow_list.push_back(r.data_in);
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (shadow_list.size() == 0) res.status = ST_POP_EMPTY;
            else if (r.op == OP_POP_FRONT) res.popped_value = shadow_list.pop_front();
            else res.popped_value = shadow_list.pop_back();
         end
         OP_CLEAR: shadow_list.delete();
         OP_SWAP: begin
            for (int k = 0; k + 1 < shadow_list.size(); k += 2) begin
               t = shadow_list[k];
               shadow_list[k] = shadow_list[k+1];
               shadow_list[k+1] = t;
            end
         end
         OP_DEDUP: begin
            foreach (shadow_list[k]) begin
               seen = 0;
               foreach (kept[j]) if (kept[j] == shadow_list[k]) seen = 1;
               if (!seen) kept.push_back(shadow_list[k]);
            end
            shadow_list = kept;
         end
         default: ;
      endcase
      res.count = 5'(shadow_list.size());
      res.is_empty = (shadow_list.size() == 0);
      res.front_value = res.is_empty ? 32'd0 : shadow_list[0];
      return res;
   endfunction

   // Values are drawn from a small pool most of the time so that dedup finds
   // duplicates; otherwise the full range is used.
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
         default: return $urandom_range(0, 5);
      endcase
   endfunction

   function automatic req_type make_req(logic [2:0] op, logic [31:0] d);
      req_type r;
      r.op = op;
      r.data_in = d;
      return r;
   endfunction

   // Stimulus: a directed opening, then random phases, each biased at random towards
   // filling the store, draining it, or mixing operations.
   initial begin
      int bias;
      int w;
      logic [2:0] op;
      pending_reqs.push_back(make_req(OP_POP_FRONT, 32'h0));
      pending_reqs.push_back(make_req(OP_POP_BACK, 32'hFFFF_FFFF));
      pending_reqs.push_back(make_req(OP_SWAP, 32'h0));
      pending_reqs.push_back(make_req(OP_DEDUP, 32'h0));
      pending_reqs.push_back(make_req(OP_UNUSED, 32'h1234));
      for (int i = 0; i < 17; i++)
         pending_reqs.push_back(make_req(i[0] ? OP_PUSH_BACK : OP_PUSH_FRONT,
                                         i[1] ? 32'hFFFF_FFFF : 32'(i[2:0])));
      pending_reqs.push_back(make_req(OP_SWAP, 32'h0));
      pending_reqs.push_back(make_req(OP_DEDUP, 32'h0));
      pending_reqs.push_back(make_req(OP_CLEAR, 32'h0));
      for (int i = 0; i < 1750; i++) begin
         if (i % 60 == 0) bias = $urandom_range(0, 2);
         w = $urandom_range(0, 99);
         if (w < 4) op = OP_SWAP;
         else if (w < 8) op = OP_DEDUP;
         else if (w < 9) op = OP_CLEAR;
         else if (w < 10) op = OP_UNUSED;
         else if (w < (bias == 0 ? 80 : bias == 1 ? 30 : 55))
            op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
         else op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
         pending_reqs.push_back(make_req(op, pick_value()));
      end
   end

   // Driver: inputs change on the falling edge only.
   initial begin
      reset = 1;
      req_valid = 0;
      req_data = '0;
      rsp_stall = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;
   end

   int send_gap = 0;
   int recv_gap = 0;
   int hold_count = 0;

   always @(negedge clock) begin
      if (!reset) begin
         // The offered transaction stays put until the block takes it.
         if (!req_valid || req_taken) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 0;
            end else if (pending_reqs.size() > 0 && !no_idling && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(0, 3);
               req_valid <= 0;
            end else if (pending_reqs.size() > 0) begin
               req_data <= pending_reqs.pop_front();
               req_valid <= 1;
            end else begin
               req_valid <= 0;
               stimulus_done = 1;
            end
         end

         // Receiver: random bursts of stall, and one long hold-off once 200 requests are taken.
         if (hold_count > 0) begin
            hold_count--;
            rsp_stall <= (hold_count > 0);
         end else if (!long_hold && accepted_reqs == 200) begin
            long_hold = 1;
            hold_count = 300;
            rsp_stall <= 1;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_stall <= 1;
         end else if (!no_idling && $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(0, 3);
            rsp_stall <= 1;
         end else begin
            rsp_stall <= 0;
         end
         no_idling = (pending_reqs.size() < 200);
      end
   end

   // Monitor: samples both channels at the rising edge.
   always @(posedge clock) begin
      rsp_type want;
      req_taken <= 0;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(deque_apply(req_data));
            req_taken <= 1;
            accepted_reqs <= accepted_reqs + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %p", rsp_data);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.popped_value !== want.popped_value
                   || rsp_data.front_value !== want.front_value
                   || rsp_data.count !== want.count
                   || rsp_data.is_empty !== want.is_empty
                   || rsp_data.status !== want.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result mismatch: expected %p, got %p", want, rsp_data);
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   // End of run and watchdog.
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
         if (stimulus_done && !req_valid && expected_rsps.size() == 0) begin
            // A quiet stretch in which any stray result is still caught.
            repeat (QUIET_TAIL) @(posedge clock);
            if (mismatches == 0 && expected_rsps.size() == 0) begin
               $display("ALL CHECKS PASSED");
            end else begin
               $display("CHECKS FAILED");
            end
            $finish;
         end
      end
   end
endmodule
